[rtl/core/abk_pkg.sv]
// Package for the angle/bias Kalman filter: payload and divider types,
// register indexes and the signed 32-bit saturation helper. No dependencies.
package abk_pkg;

   localparam int unsigned CsrIndexWidth = 2;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_ANGLE_NOISE = 2'd0,
      CSR_BIAS_NOISE  = 2'd1,
      CSR_MEAS_NOISE  = 2'd2,
      CSR_UNUSED      = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_UPDATE = 1'b0,
      OP_LOAD   = 1'b1
   } opcode_type;

   typedef struct packed {
      logic               opcode;
      logic signed [31:0] measured_angle;
      logic signed [31:0] measured_rate;
      logic [30:0]        time_step;
   } req_type;

   typedef struct packed {
      logic signed [31:0] angle_estimate;
      logic signed [31:0] bias_estimate;
      logic               saturated;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic signed [31:0] num;
      logic signed [32:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic               clip;
      logic signed [31:0] quot;
   } div_rsp_type;

   typedef struct packed {
      logic               clip;
      logic signed [31:0] val;
   } sat_type;

   function automatic sat_type sat32(input logic signed [35:0] v);
      sat_type r;
      r.clip = 1'b0;
      r.val  = v[31:0];
      if (v > 36'sd2147483647) begin
         r.clip = 1'b1;
         r.val  = 32'sh7fffffff;
      end else if (v < -36'sd2147483648) begin
         r.clip = 1'b1;
         r.val  = 32'sh80000000;
      end
      return r;
   endfunction

endpackage

[rtl/core/angle_bias_kalman_filter.sv]
// Two-state angle/bias Kalman filter, top level with its sequencer.
// Depends on abk_pkg and abk_div.
//
// One axis Kalman filter: keeps angle and gyro bias (signed Q16.16) and a
// 2x2 covariance (Q2.30). An update transfer predicts, adds process noise,
// forms both gains by division by P00 + R, corrects and shrinks the
// covariance; a load transfer sets the angle and clears the covariance.
// Every product runs through one shared registered 32x32 multiplier, and
// both gains through one restoring divider at one quotient bit per cycle.
// An update runs the sequencer through both gain divisions and its other
// steps before its result is handed over; a load goes from its load step
// straight to the handover step. req_ready is high only when idle. A
// finished result sits in the output register until taken; the next
// transfer is accepted meanwhile, and that one waits in its last step
// until the output register is free. Config writes are taken every cycle.
module angle_bias_kalman_filter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  abk_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output abk_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [abk_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [30:0]                          csr_data
);
   import abk_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE, ST_LOAD, ST_RATE, ST_MRATE, ST_ANG1, ST_COV1, ST_COV2,
      ST_COV3, ST_K0, ST_K0_WAIT, ST_K1, ST_K1_WAIT, ST_GAIN0, ST_ANG2,
      ST_BIAS, ST_C10, ST_C11, ST_C01, ST_C00, ST_DONE
   } state_type;

   state_type          state_ff;
   req_type            item_ff;
   logic [30:0]        qa_ff, qb_ff, r_ff;
   logic signed [31:0] angle_ff, bias_ff;
   logic signed [31:0] cov_ff [4];      // P00, P01, P10, P11
   logic signed [31:0] rate_ff, inner_ff, innov_ff, k0_ff, k1_ff;
   logic signed [63:0] prod_ff;
   logic               clip_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic signed [31:0] mul_a, mul_b;
   logic signed [33:0] m;               // floored product >> 30
   logic signed [35:0] sum_a, sum_b, sum_c;
   sat_type            sat_a, sat_b, sat_c;
   logic signed [31:0] dt;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign dt        = $signed({1'b0, item_ff.time_step});
   assign m         = prod_ff[63:30];
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // shared multiplier operand select: one product per step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MRATE: begin mul_a = dt;    mul_b = rate_ff;   end
         ST_ANG1:  begin mul_a = dt;    mul_b = cov_ff[3]; end
         ST_COV1:  begin mul_a = $signed({1'b0, qb_ff}); mul_b = dt; end
         ST_COV2:  begin mul_a = dt;    mul_b = inner_ff;  end
         ST_GAIN0: begin mul_a = k0_ff; mul_b = innov_ff;  end
         ST_ANG2:  begin mul_a = k1_ff; mul_b = innov_ff;  end
         ST_BIAS:  begin mul_a = k1_ff; mul_b = cov_ff[0]; end
         ST_C10:   begin mul_a = k1_ff; mul_b = cov_ff[1]; end
         ST_C11:   begin mul_a = k0_ff; mul_b = cov_ff[1]; end
         ST_C01:   begin mul_a = k0_ff; mul_b = cov_ff[0]; end
         default:  begin mul_a = '0;    mul_b = '0;        end
      endcase
   end

   // adders feeding the saturators; idle ones sit at zero (no clip)
   always_comb begin
      sum_a = '0;
      sum_b = '0;
      sum_c = '0;
      case (state_ff)
         ST_RATE: sum_a = 36'(item_ff.measured_rate) - 36'(bias_ff);
         ST_ANG1: sum_a = 36'(angle_ff) + 36'(m);
         ST_COV1: begin
            sum_a = 36'(m) - 36'(cov_ff[1]) - 36'(cov_ff[2])
                  + $signed({5'd0, qa_ff});
            sum_b = 36'(cov_ff[1]) - 36'(m);
            sum_c = 36'(cov_ff[2]) - 36'(m);
         end
         ST_COV2: sum_a = 36'(cov_ff[3]) + 36'(m);
         ST_COV3: sum_a = 36'(cov_ff[0]) + 36'(m);
         ST_K0:   sum_a = 36'(item_ff.measured_angle) - 36'(angle_ff);
         ST_ANG2: sum_a = 36'(angle_ff) + 36'(m);
         ST_BIAS: sum_a = 36'(bias_ff) + 36'(m);
         ST_C10:  sum_a = 36'(cov_ff[2]) - 36'(m);
         ST_C11:  sum_a = 36'(cov_ff[3]) - 36'(m);
         ST_C01:  sum_a = 36'(cov_ff[1]) - 36'(m);
         ST_C00:  sum_a = 36'(cov_ff[0]) - 36'(m);
         default: sum_a = '0;
      endcase
   end

   assign sat_a = sat32(sum_a);
   assign sat_b = sat32(sum_b);
   assign sat_c = sat32(sum_c);

   // gains: K0 from P00, K1 from P10, both over S = P00 + R
   assign div_req.start = (state_ff == ST_K0) || (state_ff == ST_K1);
   assign div_req.num   = (state_ff == ST_K1) ? cov_ff[2] : cov_ff[0];
   assign div_req.den   = 33'(cov_ff[0]) + $signed({2'd0, r_ff});

   abk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         qa_ff        <= 31'd1073742;
         qb_ff        <= 31'd3221225;
         r_ff         <= 31'd32212255;
         angle_ff     <= '0;
         bias_ff      <= '0;
         for (int i = 0; i < 4; i++) cov_ff[i] <= '0;
         clip_ff      <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_ANGLE_NOISE: qa_ff <= csr_data;
               CSR_BIAS_NOISE:  qb_ff <= csr_data;
               CSR_MEAS_NOISE:  r_ff  <= csr_data;
               default: ;
            endcase
         end
         // the last step refills the output register itself
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         // clip flag restarts with every transfer
         clip_ff <= (state_ff == ST_IDLE) ? 1'b0 :
                    (clip_ff | sat_a.clip | sat_b.clip | sat_c.clip
                     | (div_rsp.done & div_rsp.clip));

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  item_ff  <= req_data;
                  state_ff <= (opcode_type'(req_data.opcode) == OP_LOAD) ?
                              ST_LOAD : ST_RATE;
               end
            end
            ST_LOAD: begin
               angle_ff <= item_ff.measured_angle;
               for (int i = 0; i < 4; i++) cov_ff[i] <= '0;
               state_ff <= ST_DONE;
            end
            ST_RATE: begin
               rate_ff  <= sat_a.val;
               state_ff <= ST_MRATE;
            end
            ST_MRATE: state_ff <= ST_ANG1;
            ST_ANG1: begin
               angle_ff <= sat_a.val;
               state_ff <= ST_COV1;
            end
            ST_COV1: begin
               inner_ff  <= sat_a.val;
               cov_ff[1] <= sat_b.val;
               cov_ff[2] <= sat_c.val;
               state_ff  <= ST_COV2;
            end
            ST_COV2: begin
               cov_ff[3] <= sat_a.val;
               state_ff  <= ST_COV3;
            end
            ST_COV3: begin
               cov_ff[0] <= sat_a.val;
               state_ff  <= ST_K0;
            end
            ST_K0: begin
               innov_ff <= sat_a.val;
               state_ff <= ST_K0_WAIT;
            end
            ST_K0_WAIT: begin
               if (div_rsp.done) begin
                  k0_ff    <= div_rsp.quot;
                  state_ff <= ST_K1;
               end
            end
            ST_K1: state_ff <= ST_K1_WAIT;
            ST_K1_WAIT: begin
               if (div_rsp.done) begin
                  k1_ff    <= div_rsp.quot;
                  state_ff <= ST_GAIN0;
               end
            end
            ST_GAIN0: state_ff <= ST_ANG2;
            ST_ANG2: begin
               angle_ff <= sat_a.val;
               state_ff <= ST_BIAS;
            end
            ST_BIAS: begin
               bias_ff  <= sat_a.val;
               state_ff <= ST_C10;
            end
            ST_C10: begin
               cov_ff[2] <= sat_a.val;
               state_ff  <= ST_C11;
            end
            ST_C11: begin
               cov_ff[3] <= sat_a.val;
               state_ff  <= ST_C01;
            end
            ST_C01: begin
               cov_ff[1] <= sat_a.val;
               state_ff  <= ST_C00;
            end
            ST_C00: begin
               cov_ff[0] <= sat_a.val;
               state_ff  <= ST_DONE;
            end
            ST_DONE: begin
               // hand over once the output register is free
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.angle_estimate <= angle_ff;
                  rsp_ff.bias_estimate  <= bias_ff;
                  rsp_ff.saturated      <= clip_ff;
                  rsp_valid_ff          <= 1'b1;
                  state_ff              <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // no second transfer while one is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("transfer accepted while busy");

   // divider only answers while the sequencer waits for a gain
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_K0_WAIT || state_ff == ST_K1_WAIT))
      else $error("unexpected divider completion");

   // a load leaves a cleared covariance
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |=> (cov_ff[0] == '0 && cov_ff[1] == '0
                                 && cov_ff[2] == '0 && cov_ff[3] == '0))
      else $error("covariance not cleared by load");

endmodule

[rtl/core/abk_div.sv]
// Iterative restoring divider for the Kalman gains: (num * 2^30) / den,
// truncated toward zero and saturated to 32 bits. Uses abk_pkg.
module abk_div (
   input  logic                 clock,
   input  logic                 reset,
   input  abk_pkg::div_req_type div_req,
   output abk_pkg::div_rsp_type div_rsp
);
   import abk_pkg::*;

   logic        busy_ff;
   logic [5:0]  cnt_ff;
   logic        neg_ff;
   logic        zero_ff;
   logic [61:0] quo_ff;
   logic [32:0] dvs_ff;
   logic [32:0] rem_ff;
   div_rsp_type rsp_ff;

   logic [33:0] trial;
   logic [33:0] diff;
   logic [31:0] num_mag;
   logic [32:0] den_mag;

   assign num_mag = div_req.num[31] ? 32'(-div_req.num) : 32'(div_req.num);
   assign den_mag = div_req.den[32] ? 33'(-div_req.den) : 33'(div_req.den);
   assign trial   = {rem_ff, quo_ff[61]};
   assign diff    = trial - {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= 6'd62;
            neg_ff  <= div_req.num[31] ^ div_req.den[32];
            zero_ff <= (div_req.den == '0);
            quo_ff  <= {num_mag, 30'd0};
            dvs_ff  <= den_mag;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            if (cnt_ff != '0) begin
               cnt_ff <= cnt_ff - 6'd1;
               if (!diff[33]) begin
                  rem_ff <= diff[32:0];
                  quo_ff <= {quo_ff[60:0], 1'b1};
               end else begin
                  rem_ff <= trial[32:0];
                  quo_ff <= {quo_ff[60:0], 1'b0};
               end
            end else begin
               busy_ff     <= 1'b0;
               rsp_ff.done <= 1'b1;
               rsp_ff.clip <= 1'b0;
               if (zero_ff) begin
                  rsp_ff.quot <= '0;
               end else if (!neg_ff) begin
                  if (quo_ff > 62'h7fffffff) begin
                     rsp_ff.clip <= 1'b1;
                     rsp_ff.quot <= 32'sh7fffffff;
                  end else begin
                     rsp_ff.quot <= quo_ff[31:0];
                  end
               end else begin
                  if (quo_ff > 62'h80000000) begin
                     rsp_ff.clip <= 1'b1;
                     rsp_ff.quot <= 32'sh80000000;
                  end else begin
                     rsp_ff.quot <= 32'(-quo_ff[31:0]);
                  end
               end
            end
         end
      end
   end

   assign div_rsp = rsp_ff;

endmodule

[tb/sv/abk_checker.sv]
// Checker for the angle/bias Kalman filter: watches the request, response and
// register-write channels, predicts every response and compares. Uses abk_pkg.
`timescale 1ns / 100ps

module abk_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_ready,
   input  abk_pkg::req_type                  req_data,
   input  logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  abk_pkg::rsp_type                  rsp_data,
   input  logic                              csr_valid,
   input  logic                              csr_ready,
   input  logic [abk_pkg::CsrIndexWidth-1:0] csr_index,
   input  logic [30:0]                       csr_data,
   output int                                fail_count,
   output int                                pending,
   output int                                checked
);
   import abk_pkg::*;

   localparam longint Q30_ONE = 64'sd1073741824;

   // filter state mirrored from the block
   longint    angle_noise, bias_noise, meas_noise;
   longint    angle_q16, bias_q16;
   longint    cov [4];
   bit        clipped;
   rsp_type   expected_rsp [$];

   function automatic longint clip32(longint v);
      if (v > 64'sd2147483647) begin
         clipped = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         clipped = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   // exact product, floored shift by 30 (arithmetic shift floors)
   function automatic longint qmul(longint a, longint b);
      return (a * b) >>> 30;
   endfunction

   function automatic longint kgain(longint num, longint den);
      if (den == 0) return 0;
      return clip32((num * Q30_ONE) / den);
   endfunction

   function automatic rsp_type filter_step(req_type item);
      longint  dt, rate, inner, k0, k1, innov, s;
      longint  n00, n01, n10, n11;
      rsp_type r;
      dt      = longint'({33'd0, item.time_step});
      clipped = 1'b0;
      if (item.opcode == OP_LOAD) begin
         angle_q16 = longint'(item.measured_angle);
         foreach (cov[i]) cov[i] = 0;
      end else begin
         rate      = clip32(longint'(item.measured_rate) - bias_q16);
         angle_q16 = clip32(angle_q16 + qmul(dt, rate));
         inner     = clip32(qmul(dt, cov[3]) - cov[1] - cov[2] + angle_noise);
         n00       = clip32(cov[0] + qmul(dt, inner));
         n01       = clip32(cov[1] - qmul(dt, cov[3]));
         n10       = clip32(cov[2] - qmul(dt, cov[3]));
         n11       = clip32(cov[3] + qmul(bias_noise, dt));
         s         = n00 + meas_noise;
         k0        = kgain(n00, s);
         k1        = kgain(n10, s);
         innov     = clip32(longint'(item.measured_angle) - angle_q16);
         angle_q16 = clip32(angle_q16 + qmul(k0, innov));
         bias_q16  = clip32(bias_q16 + qmul(k1, innov));
         cov[0]    = clip32(n00 - qmul(k0, n00));
         cov[1]    = clip32(n01 - qmul(k0, n01));
         cov[2]    = clip32(n10 - qmul(k1, n00));
         cov[3]    = clip32(n11 - qmul(k1, n01));
      end
      r.angle_estimate = angle_q16[31:0];
      r.bias_estimate  = bias_q16[31:0];
      r.saturated      = clipped;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         angle_noise = 1073742;
         bias_noise  = 3221225;
         meas_noise  = 32212255;
         angle_q16   = 0;
         bias_q16    = 0;
         foreach (cov[i]) cov[i] = 0;
         expected_rsp.delete();
         fail_count  = 0;
         checked     = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_ANGLE_NOISE: angle_noise = longint'({33'd0, csr_data});
               CSR_BIAS_NOISE:  bias_noise  = longint'({33'd0, csr_data});
               CSR_MEAS_NOISE:  meas_noise  = longint'({33'd0, csr_data});
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(filter_step(req_data));
         if (rsp_valid && rsp_ready) begin
            checked++;
            if (expected_rsp.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected response transfer: %p", rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.angle_estimate !== want.angle_estimate
                   || rsp_data.bias_estimate !== want.bias_estimate
                   || rsp_data.saturated !== want.saturated) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch at response %0d: expected %p, got %p",
                              checked, want, rsp_data);
               end
            end
         end
      end
      pending = expected_rsp.size();
   end

endmodule

[tb/sv/tb_angle_bias_kalman_filter.sv]
// Top of the angle/bias Kalman filter testbench: clock, reset, stimulus,
// handshake pressure and verdict. Depends on abk_pkg, the block and abk_checker.
`timescale 1ns / 100ps

module tb_angle_bias_kalman_filter;
   import abk_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_valid, req_ready;
   req_type       req_data;
   logic          rsp_valid, rsp_ready;
   rsp_type       rsp_data;
   logic          csr_valid, csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [30:0]   csr_data;

   int            fail_count, pending, checked;
   int            tx_idle_pct, rx_idle_pct;
   int            n_items, n_loads;
   bit            hold_request, hold_on;

   angle_bias_kalman_filter u_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   abk_checker u_checker (
      .clock, .reset,
      .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .rsp_data,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .fail_count, .pending, .checked
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !hold_on && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // long hold-off, counted here; the sender keeps offering so the block fills
   initial begin
      hold_on = 1'b0;
      wait (hold_request);
      @(posedge clock);
      hold_on <= 1'b1;
      repeat (3000) @(posedge clock);
      hold_on <= 1'b0;
   end

   // one request transfer, with a random gap in front of it
   task automatic send_req(req_type item);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < tx_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      n_items++;
      if (item.opcode == OP_LOAD) n_loads++;
   endtask

   task automatic send_fields(opcode_type op, logic [31:0] ang, logic [31:0] rate,
                              logic [30:0] dt);
      req_type item;
      item.opcode         = op;
      item.measured_angle = ang;
      item.measured_rate  = rate;
      item.time_step      = dt;
      send_req(item);
   endtask

   // stop offering, wait for every response, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [30:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_noise(logic [30:0] qa, logic [30:0] qb, logic [30:0] r);
      write_reg(CSR_ANGLE_NOISE, qa);
      write_reg(CSR_BIAS_NOISE, qb);
      write_reg(CSR_MEAS_NOISE, r);
   endtask

   // mostly plausible IMU traffic; some loads and some full-range noise
   task automatic send_random();
      int          pick;
      req_type     item;
      pick = $urandom_range(99);
      if (pick < 12) begin
         item = {$urandom, $urandom, $urandom};
         send_req(item);
      end else if (pick < 17) begin
         send_fields(OP_LOAD, $urandom_range(23_592_960) - 11_796_480, $urandom,
                     31'($urandom));
      end else begin
         // angle within +-180 deg, rate within +-500 deg/s, dt up to ~20 ms
         send_fields(OP_UPDATE, $urandom_range(23_592_960) - 11_796_480,
                     $urandom_range(65_536_000) - 32_768_000,
                     31'($urandom_range(21_474_836, 1)));
      end
   endtask

   initial begin
      logic [30:0] qa, qb, r;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_index    = CSR_ANGLE_NOISE;
      csr_data     = '0;
      tx_idle_pct  = 10;
      rx_idle_pct  = 49;
      hold_request = 1'b0;
      n_items      = 0;
      n_loads      = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults written back explicitly; the spare index must be ignored
      write_noise(31'd1073742, 31'd3221225, 31'd32212255);
      write_reg(CSR_UNUSED, 31'h7fffffff);

      // directed: field extremes, both operations
      send_fields(OP_LOAD, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
      send_fields(OP_UPDATE, 32'sh80000000, 32'sh7fffffff, 31'h7fffffff);
      send_fields(OP_UPDATE, 32'sh7fffffff, 32'sh80000000, 31'h7fffffff);
      send_fields(OP_UPDATE, 32'sh0, 32'sh0, 31'd0);
      send_fields(OP_LOAD, 32'sh80000000, 32'sh7fffffff, 31'd0);
      send_fields(OP_UPDATE, 32'sh0, 32'sh7fffffff, 31'd1);
      send_fields(OP_LOAD, 32'sh0, 32'sh0, 31'd0);
      send_fields(OP_UPDATE, 32'sh000a0000, 32'sh00010000, 31'd1073742);
      send_fields(OP_UPDATE, 32'shfff60000, 32'shffff0000, 31'd10737418);
      send_fields(OP_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 31'h40000000);
      drain();

      // zero divisor: no noise at all and a cleared covariance
      write_noise(31'd0, 31'd0, 31'd0);
      send_fields(OP_LOAD, 32'sh00050000, 32'sh0, 31'd0);
      send_fields(OP_UPDATE, 32'sh00100000, 32'sh00020000, 31'd1073742);
      send_fields(OP_UPDATE, 32'shfff00000, 32'shfffe0000, 31'h7fffffff);
      drain();

      // largest noise: covariance saturates, divisor may turn negative
      write_noise(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      repeat (6) send_fields(OP_UPDATE, $urandom, $urandom, 31'h7fffffff);
      send_fields(OP_UPDATE, 32'sh80000000, 32'sh80000000, 31'h7fffffff);
      send_fields(OP_UPDATE, 32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff);
      drain();
      write_noise(31'h7fffffff, 31'd0, 31'd1);
      repeat (4) send_fields(OP_UPDATE, $urandom, $urandom, 31'h7fffffff);
      drain();

      // random part in seven chunks, idling pattern changing every few chunks
      for (int chunk = 0; chunk < 7; chunk++) begin
         if (chunk < 3) begin
            tx_idle_pct = 10;
            rx_idle_pct = 49;
         end else if (chunk < 5) begin
            tx_idle_pct = 49;
            rx_idle_pct = 10;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         if ($urandom_range(3) == 0) begin
            qa = 31'($urandom);
            qb = 31'($urandom);
            r  = 31'($urandom);
         end else begin
            qa = 31'($urandom_range(10_737_418));
            qb = 31'($urandom_range(32_212_254));
            r  = 31'($urandom_range(107_374_182));
         end
         write_noise(qa, qb, r);
         if (chunk == 1) hold_request = 1'b1;
         repeat (200) send_random();
         drain();
      end

      $display("run covered %0d request transfers (%0d loads), %0d responses checked",
               n_items, n_loads, checked);
      $display("noise settings from zero to full scale, with stalls on both sides");
      if (fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/abk_pkg.sv
rtl/core/abk_div.sv
rtl/core/angle_bias_kalman_filter.sv
tb/sv/abk_checker.sv
tb/sv/tb_angle_bias_kalman_filter.sv
